/* sv/pps_pkg.sv */
// Package with the shared types and codes of the preemptive priority scheduler.
`default_nettype none

package pps_pkg;

  localparam int ARR_W   = 16;
  localparam int BURST_W = 16;
  localparam int PRIO_W  = 8;
  localparam int TIME_W  = 32;
  localparam int PID_W   = 5;
  localparam int STS_W   = 2;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  localparam logic [STS_W-1:0] STATUS_LOADED   = 2'd0;
  localparam logic [STS_W-1:0] STATUS_REJECTED = 2'd1;
  localparam logic [STS_W-1:0] STATUS_RAN      = 2'd2;
  localparam logic [STS_W-1:0] STATUS_IDLE     = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_COMMIT
  } ctl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;   // capture the request and restart the search
    logic rd_en;    // read the next table slot
    logic commit;   // apply the request and load the result register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_is_load;  // the offered request is a load
    logic cnt_zero;    // no process loaded
    logic scan_last;   // the slot being read is the last loaded one
    logic out_free;    // the result register can take a new result
  } dp_sts_t;

endpackage

`default_nettype wire

/* sv/pps_ctrl.sv */
// Controller state machine of the preemptive priority scheduler.
`default_nettype none

module pps_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  output logic             in_ready,
  input  wire pps_pkg::dp_sts_t sts,
  output pps_pkg::dp_cmd_t cmd
);
  import pps_pkg::*;

  ctl_state_t state;
  ctl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (sts.in_is_load || sts.cnt_zero) begin
            state_next = S_COMMIT;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (sts.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        if (sts.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd.accept = 1'b0;
    cmd.rd_en  = 1'b0;
    cmd.commit = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      S_SCAN: begin
        cmd.rd_en = 1'b1;
      end
      S_DRAIN: begin
      end
      S_COMMIT: begin
        cmd.commit = sts.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

/* sv/pps_dp.sv */
// Datapath of the preemptive priority scheduler: process table, search and result register.
`default_nettype none

module pps_dp #(
  parameter int MAX_PROCS = 16
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire pps_pkg::dp_cmd_t              cmd,
  output pps_pkg::dp_sts_t                   sts,
  input  wire                                req_type,
  input  wire [pps_pkg::ARR_W-1:0]           arrival_time,
  input  wire [pps_pkg::BURST_W-1:0]         burst_len,
  input  wire [pps_pkg::PRIO_W-1:0]          prio_level,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic [pps_pkg::STS_W-1:0]          status,
  output logic [pps_pkg::PID_W-1:0]          proc_id,
  output logic                               finished,
  output logic [pps_pkg::TIME_W-1:0]         completion_time,
  output logic [pps_pkg::TIME_W-1:0]         turnaround_time,
  output logic [pps_pkg::TIME_W-1:0]         waiting_time,
  output logic                               all_done
);
  import pps_pkg::*;

  localparam int IDX_W   = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W   = $clog2(MAX_PROCS + 1);
  localparam int ENTRY_W = ARR_W + BURST_W + PRIO_W + BURST_W;

  // Table entry layout: arrival, burst, priority, remaining work.
  logic [ENTRY_W-1:0] mem [MAX_PROCS];
  logic [ENTRY_W-1:0] rd_data;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;

  // Captured request.
  logic               cap_type;
  logic [ARR_W-1:0]   cap_arr;
  logic [BURST_W-1:0] cap_bur;
  logic [PRIO_W-1:0]  cap_prio;

  // Scheduler state.
  logic [TIME_W-1:0]  current_time;
  logic [CNT_W-1:0]   loaded_count;
  logic [CNT_W-1:0]   completed_count;

  // Search state.
  logic [IDX_W-1:0]   scan_idx;
  logic               rd_vld;
  logic [IDX_W-1:0]   rd_idx;
  logic               found;
  logic [IDX_W-1:0]   best_idx;
  logic [ARR_W-1:0]   best_arr;
  logic [BURST_W-1:0] best_bur;
  logic [PRIO_W-1:0]  best_prio;
  logic [BURST_W-1:0] best_rem;

  logic [ARR_W-1:0]   rd_arr;
  logic [BURST_W-1:0] rd_bur;
  logic [PRIO_W-1:0]  rd_prio;
  logic [BURST_W-1:0] rd_rem;
  logic               cand;

  // Commit results.
  logic [TIME_W-1:0]  time_next;
  logic [BURST_W-1:0] rem_dec;
  logic [TIME_W-1:0]  turn;
  logic               fin;
  logic               full;
  logic [CNT_W-1:0]   loaded_next;
  logic [CNT_W-1:0]   completed_next;
  logic [TIME_W-1:0]  current_time_next;
  logic [STS_W-1:0]   res_status;
  logic [PID_W-1:0]   res_pid;
  logic               res_fin;
  logic [TIME_W-1:0]  res_comp;
  logic [TIME_W-1:0]  res_turn;
  logic [TIME_W-1:0]  res_wait;

  assign sts.in_is_load = (req_type == REQ_LOAD);
  assign sts.cnt_zero   = (loaded_count == '0);
  assign sts.scan_last  = ((CNT_W'(scan_idx) + CNT_W'(1)) == loaded_count);
  assign sts.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[scan_idx];
    end
  end

  assign {rd_arr, rd_bur, rd_prio, rd_rem} = rd_data;

  assign cand = (TIME_W'(rd_arr) <= current_time) && (rd_rem != '0) &&
                (!found || (rd_prio < best_prio));

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cap_type <= req_type;
      cap_arr  <= arrival_time;
      cap_bur  <= burst_len;
      cap_prio <= prio_level;
    end
    if (rd_vld && cand) begin
      best_idx  <= rd_idx;
      best_arr  <= rd_arr;
      best_bur  <= rd_bur;
      best_prio <= rd_prio;
      best_rem  <= rd_rem;
    end
    rd_idx <= scan_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld          <= 1'b0;
      found           <= 1'b0;
      scan_idx        <= '0;
      current_time    <= '0;
      loaded_count    <= '0;
      completed_count <= '0;
    end else begin
      rd_vld <= cmd.rd_en;
      if (cmd.accept) begin
        found    <= 1'b0;
        scan_idx <= '0;
      end else begin
        if (rd_vld && cand) begin
          found <= 1'b1;
        end
        if (cmd.rd_en) begin
          scan_idx <= scan_idx + IDX_W'(1);
        end
      end
      if (cmd.commit) begin
        current_time    <= current_time_next;
        loaded_count    <= loaded_next;
        completed_count <= completed_next;
      end
    end
  end

  always_comb begin
    time_next = (current_time == '1) ? current_time : current_time + TIME_W'(1);
    rem_dec   = best_rem - BURST_W'(1);
    fin       = found && (rem_dec == '0);
    turn      = time_next - TIME_W'(best_arr);
    full      = (loaded_count == CNT_W'(MAX_PROCS));

    mem_we            = 1'b0;
    mem_waddr         = best_idx;
    mem_wdata         = {best_arr, best_bur, best_prio, rem_dec};
    loaded_next       = loaded_count;
    completed_next    = completed_count;
    current_time_next = current_time;
    res_status        = STATUS_IDLE;
    res_pid           = '0;
    res_fin           = 1'b0;
    res_comp          = '0;
    res_turn          = '0;
    res_wait          = '0;

    if (cap_type == REQ_LOAD) begin
      if (full) begin
        res_status = STATUS_REJECTED;
      end else begin
        mem_we      = cmd.commit;
        mem_waddr   = loaded_count[IDX_W-1:0];
        mem_wdata   = {cap_arr, cap_bur, cap_prio, cap_bur};
        loaded_next = loaded_count + CNT_W'(1);
        if (cap_bur == '0) begin
          completed_next = completed_count + CNT_W'(1);
        end
        res_status = STATUS_LOADED;
        res_pid    = PID_W'(loaded_count) + PID_W'(1);
      end
    end else begin
      current_time_next = time_next;
      if (found) begin
        mem_we     = cmd.commit;
        res_status = STATUS_RAN;
        res_pid    = PID_W'(best_idx) + PID_W'(1);
        if (fin) begin
          completed_next = completed_count + CNT_W'(1);
          res_fin        = 1'b1;
          res_comp       = time_next;
          res_turn       = turn;
          res_wait       = (turn >= TIME_W'(best_bur)) ? turn - TIME_W'(best_bur) : '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status          <= res_status;
      proc_id         <= res_pid;
      finished        <= res_fin;
      completion_time <= res_comp;
      turnaround_time <= res_turn;
      waiting_time    <= res_wait;
      all_done        <= (completed_next == loaded_next);
    end
  end

endmodule

`default_nettype wire

/* sv/preemptive_priority_scheduler.sv */
// Top level of the preemptive priority scheduler: controller plus datapath.
//
// Usage: the input channel (in_valid/in_ready) carries one request per
// transaction. A load request (req_type 0) stores a process with its arrival
// tick, burst length and priority in the next free slot, or is rejected when
// the table is full. A tick request (req_type 1) runs the arrived process with
// the lowest priority number for one unit of time, ties going to the lowest
// slot, and advances the clock of the schedule, which saturates at its maximum.
// The output channel (out_valid/out_ready) returns exactly one result
// transaction per request, with completion, turnaround and waiting times when
// a process finishes.
// Sequencing: a load goes from acceptance straight to the commit state, which
// loads the result register and returns to idle for the next request. A tick
// reads the table one slot per cycle through the single read port: it stays in
// the scan state until the last loaded slot is read, then passes the drain state
// to commit (no scan with an empty table). A new request is taken only in idle.
// The result sits in an output register, so the next request is accepted
// while a result waits; if the receiver stalls, the block holds that request
// until the register is free. Reset clears time and counters; the table
// contents need no clearing, since only loaded slots are read.
`default_nettype none

module preemptive_priority_scheduler #(
  parameter int MAX_PROCS = 16
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire                         req_type,
  input  wire [pps_pkg::ARR_W-1:0]    arrival_time,
  input  wire [pps_pkg::BURST_W-1:0]  burst_len,
  input  wire [pps_pkg::PRIO_W-1:0]   prio_level,
  output logic                        out_valid,
  input  wire                         out_ready,
  output logic [pps_pkg::STS_W-1:0]   status,
  output logic [pps_pkg::PID_W-1:0]   proc_id,
  output logic                        finished,
  output logic [pps_pkg::TIME_W-1:0]  completion_time,
  output logic [pps_pkg::TIME_W-1:0]  turnaround_time,
  output logic [pps_pkg::TIME_W-1:0]  waiting_time,
  output logic                        all_done
);
  import pps_pkg::*;

  // Command and status bundles between the controller and the datapath.
  dp_cmd_t cmd;
  dp_sts_t sts;

  // The controller sequences accept, table scan and commit.
  pps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the table, the search registers and the result register.
  pps_dp #(
    .MAX_PROCS (MAX_PROCS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .req_type        (req_type),
    .arrival_time    (arrival_time),
    .burst_len       (burst_len),
    .prio_level      (prio_level),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .proc_id         (proc_id),
    .finished        (finished),
    .completion_time (completion_time),
    .turnaround_time (turnaround_time),
    .waiting_time    (waiting_time),
    .all_done        (all_done)
  );

endmodule

`default_nettype wire
